>>> rtl/core/tilt_complementary_filter_unit_assert.svh
// assertion macros for the tilt filter checker
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_ASSERT_SVH
// implication checked every clock, muted in reset
`define TCF_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define TCF_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

>>> rtl/core/tcf_pkg.sv
// shared constants, tables and types of the tilt filter
`timescale 1ns / 1ps
package tcf_pkg;
   localparam int CordicIterations = 16;
   localparam int IterW = $clog2(CordicIterations + 1);
   localparam int Deg180 = 11796480;
   localparam int Deg360 = 23592960;
   localparam int GainOne = 65536;
   localparam logic [0:0] CSR_BLEND_GAIN = 1'b0;
   localparam logic [0:0] CSR_STEP_TIME = 1'b1;

   function automatic logic signed [25:0] atan_entry(input logic [4:0] i);
      logic signed [25:0] v;
      case (i)
         5'd0: v = 26'sd2949120;  5'd1: v = 26'sd1740967;
         5'd2: v = 26'sd919879;   5'd3: v = 26'sd466945;
         5'd4: v = 26'sd234379;   5'd5: v = 26'sd117305;
         5'd6: v = 26'sd58666;    5'd7: v = 26'sd29335;
         5'd8: v = 26'sd14668;    5'd9: v = 26'sd7334;
         5'd10: v = 26'sd3667;    5'd11: v = 26'sd1833;
         5'd12: v = 26'sd917;     5'd13: v = 26'sd458;
         5'd14: v = 26'sd229;     5'd15: v = 26'sd115;
         5'd16: v = 26'sd57;      5'd17: v = 26'sd29;
         5'd18: v = 26'sd14;      5'd19: v = 26'sd7;
         5'd20: v = 26'sd4;       5'd21: v = 26'sd2;
         5'd22: v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic load;      // capture sample, init cordic
      logic iterate;   // one cordic step on both vectors
      logic fin_angle; // final offset and clamp, gyro prediction
      logic blend_a;   // gain products, roll
      logic blend_b;   // gain products, pitch
      logic commit;    // round, saturate, update state and output
   } cmd_type;

   typedef struct packed {
      logic iter_done;
   } status_type;
endpackage

>>> rtl/core/tcf_control.sv
// sequencer of the tilt filter
`timescale 1ns / 1ps
module tcf_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  tcf_pkg::status_type status,
   output tcf_pkg::cmd_type cmd,
   output logic busy
);
   import tcf_pkg::*;
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_ITER = 6'b000010, S_FIN = 6'b000100,
      S_BLA = 6'b001000, S_BLB = 6'b010000, S_DONE = 6'b100000
   } state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // a new sample may enter while the last result still waits
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign busy = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_ITER;
            end
         end
         S_ITER: begin
            cmd.iterate = 1'b1;
            if (status.iter_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin_angle = 1'b1;
            state_in = S_BLA;
         end
         S_BLA: begin
            cmd.blend_a = 1'b1;
            state_in = S_BLB;
         end
         S_BLB: begin
            cmd.blend_b = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> rtl/core/tcf_datapath.sv
// cordic, blend arithmetic and estimate registers of the tilt filter
`timescale 1ns / 1ps
module tcf_datapath (
   input  logic clock,
   input  logic reset,
   input  tcf_pkg::cmd_type cmd,
   output tcf_pkg::status_type status,
   input  logic busy,
   input  logic csr_valid,
   input  logic [0:0] csr_index,
   input  logic csr_index_hi,
   input  logic [16:0] csr_data,
   input  logic signed [15:0] req_rate_roll,
   input  logic signed [15:0] req_rate_pitch,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic signed [31:0] rsp_roll_estimate,
   output logic signed [31:0] rsp_pitch_estimate,
   output logic [24:0] rsp_roll_from_accel,
   output logic [24:0] rsp_pitch_from_accel
);
   import tcf_pkg::*;
   logic [16:0] gain_ff;
   logic [9:0] step_ff;
   logic signed [31:0] roll_state_ff, pitch_state_ff;
   // two vectors: 0 roll (y,z), 1 pitch (x,z)
   logic signed [19:0] x_ff [2], y_ff [2];
   logic signed [26:0] ang_ff [2];
   logic fixed_ff [2];
   logic [IterW-1:0] iter_ff;
   logic signed [15:0] rate_ff [2];
   logic [24:0] acc_ff [2];
   logic signed [35:0] pred_ff [2];
   logic signed [50:0] sum_ff [2];
   logic signed [31:0] est_ff [2];
   logic [24:0] acc_out_ff [2];
   logic [16:0] g;
   logic [17:0] gc;

   assign status.iter_done = iter_ff == IterW'(CordicIterations - 1);
   assign g = (gain_ff > 17'(GainOne)) ? 17'(GainOne) : gain_ff;
   assign gc = 18'(GainOne) - {1'b0, g};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 17'd62259;
         step_ff <= 10'd10;
      end else if (csr_valid && !busy && !csr_index_hi) begin
         unique case (csr_index)
            CSR_BLEND_GAIN: gain_ff <= csr_data;
            CSR_STEP_TIME: step_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [26:0] fin(input logic signed [26:0] a,
                                              input logic f, input logic [24:0] fv);
      logic signed [27:0] t;
      t = 28'(a) + 28'(Deg180);
      if (f) return 27'(fv);
      if (t < 0) return 27'sd0;
      if (t > 28'(Deg360)) return 27'(Deg360);
      return 27'(t);
   endfunction

   function automatic logic signed [31:0] r_sat(input logic signed [50:0] v);
      logic signed [50:0] r;
      r = (v + 51'sd32768) >>> 16;
      if (r > 51'sd2147483647) return 32'sh7fffffff;
      if (r < -51'sd2147483648) return 32'sh80000000;
      return 32'(r);
   endfunction

   always_ff @(posedge clock) begin
      logic signed [15:0] num [2];
      logic signed [19:0] sx, sy;
      logic signed [26:0] sr;
      logic signed [50:0] bs;
      logic kb;
      int k;
      if (reset) begin
         roll_state_ff <= '0;
         pitch_state_ff <= '0;
         iter_ff <= '0;
      end else begin
         num[0] = req_accel_y;
         num[1] = req_accel_x;
         if (cmd.load) begin
            iter_ff <= '0;
            rate_ff[0] <= req_rate_roll;
            rate_ff[1] <= req_rate_pitch;
            for (k = 0; k < 2; k++) begin
               fixed_ff[k[0]] <= num[k[0]] == 0;
               acc_ff[k[0]] <= (req_accel_z >= 0) ? 25'(Deg180) : 25'(Deg360);
               if (req_accel_z < 0) begin
                  x_ff[k[0]] <= -20'(req_accel_z);
                  y_ff[k[0]] <= -20'(num[k[0]]);
                  ang_ff[k[0]] <= (num[k[0]] >= 0) ? 27'(Deg180) : -27'(Deg180);
               end else begin
                  x_ff[k[0]] <= 20'(req_accel_z);
                  y_ff[k[0]] <= 20'(num[k[0]]);
                  ang_ff[k[0]] <= '0;
               end
            end
         end
         if (cmd.iterate) begin
            iter_ff <= iter_ff + 1'b1;
            for (k = 0; k < 2; k++) begin
               sx = x_ff[k[0]] >>> iter_ff;
               sy = y_ff[k[0]] >>> iter_ff;
               if (y_ff[k[0]] > 0) begin
                  x_ff[k[0]] <= x_ff[k[0]] + sy;
                  y_ff[k[0]] <= y_ff[k[0]] - sx;
                  ang_ff[k[0]] <= ang_ff[k[0]] + 27'(atan_entry(5'(iter_ff)));
               end else begin
                  x_ff[k[0]] <= x_ff[k[0]] - sy;
                  y_ff[k[0]] <= y_ff[k[0]] + sx;
                  ang_ff[k[0]] <= ang_ff[k[0]] - 27'(atan_entry(5'(iter_ff)));
               end
            end
         end
         if (cmd.fin_angle) begin
            for (k = 0; k < 2; k++) begin
               acc_ff[k[0]] <= 25'(fin(ang_ff[k[0]], fixed_ff[k[0]], acc_ff[k[0]]));
               // gyro prediction: estimate plus step times rate, widened to q20.16
               sr = $signed({1'b0, step_ff}) * rate_ff[k[0]];
               pred_ff[k[0]] <= 36'(k[0] ? pitch_state_ff : roll_state_ff)
                              + 36'($signed({sr, 8'b0}));
            end
         end
         if (cmd.blend_a || cmd.blend_b) begin
            kb = cmd.blend_b;
            bs = $signed(gc) * pred_ff[kb] + $signed({1'b0, g}) * $signed({1'b0, acc_ff[kb]});
            sum_ff[kb] <= bs;
         end
         if (cmd.commit) begin
            for (k = 0; k < 2; k++) begin
               est_ff[k[0]] <= r_sat(sum_ff[k[0]]);
               acc_out_ff[k[0]] <= acc_ff[k[0]];
            end
            roll_state_ff <= (r_sat(sum_ff[0]));
            pitch_state_ff <= (r_sat(sum_ff[1]));
         end
      end
   end

   assign rsp_roll_estimate = est_ff[0];
   assign rsp_pitch_estimate = est_ff[1];
   assign rsp_roll_from_accel = acc_out_ff[0];
   assign rsp_pitch_from_accel = acc_out_ff[1];
endmodule

>>> rtl/core/tilt_complementary_filter_unit.sv
// top level of the tilt complementary filter
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | gyro rates, accelerations
//  rsp     | out       | rsp_valid/stall  | estimates, accel angles
//  csr     | in        | csr_valid/ready  | register index, data
// a sample runs load, the cordic steps, final angle, roll and pitch blends and commit,
// with the shared cordic stepping both vectors once a cycle.
// reset is synchronous and restores gain, step time and zero estimates.
// a held result stalls only the commit of the next sample.
`timescale 1ns / 1ps
module tilt_complementary_filter_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_rate_roll,
   input  logic signed [15:0] req_rate_pitch,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_roll_estimate,
   output logic signed [31:0] rsp_pitch_estimate,
   output logic [24:0] rsp_roll_from_accel,
   output logic [24:0] rsp_pitch_from_accel,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [7:0] csr_index,
   input  logic [31:0] csr_data
);
   import tcf_pkg::*;
   cmd_type cmd;
   status_type status;
   logic busy;

   assign csr_ready = !busy;

   tcf_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd, .busy
   );

   tcf_datapath u_dp (
      .clock, .reset, .cmd, .status, .busy, .csr_valid,
      .csr_index(csr_index[0:0]), .csr_index_hi(|csr_index[7:1]),
      .csr_data(csr_data[16:0]),
      .req_rate_roll, .req_rate_pitch, .req_accel_x, .req_accel_y, .req_accel_z,
      .rsp_roll_estimate, .rsp_pitch_estimate,
      .rsp_roll_from_accel, .rsp_pitch_from_accel
   );
endmodule

>>> rtl/core/tcf_checker.sv
// port-level checker of the tilt filter, bound to the top level
`timescale 1ns / 1ps
`include "tilt_complementary_filter_unit_assert.svh"
module tcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_ready,
   input logic [31:0] rsp_roll_estimate
);
   `TCF_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `TCF_ASSERT_IMPL(a_accept_idle, clock, reset, req_valid && !req_stall, csr_ready)
   `TCF_ASSERT_IMPL(a_csr_idle, clock, reset, !csr_ready, req_stall)
   `TCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_roll_estimate))
endmodule

bind tilt_complementary_filter_unit tcf_checker u_tcf_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .csr_ready,
   .rsp_roll_estimate
);
